>>> rtl/core/epoch_seconds_to_calendar_assert.svh
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: assertion macros
// Shared assertion forms for the converter modules. They expect clk_i and
// rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define E2C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define E2C_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/e2cal_pkg.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: package
// Constants, command and status types and small calendar tables.
// ----------------------------------------------------------------------------
package e2cal_pkg;

  localparam logic [24:0] SecsCommonYear = 25'd31536000;
  localparam logic [24:0] SecsLeapYear   = 25'd31622400;
  localparam logic [16:0] SecsPerDay     = 17'd86400;
  localparam logic [11:0] SecsPerHour    = 12'd3600;
  localparam logic [5:0]  SecsPerMin     = 6'd60;
  localparam logic [11:0] EpochYear      = 12'd1970;
  localparam logic [6:0]  EpochMod100    = 7'd70;
  localparam logic [8:0]  EpochMod400    = 9'd370;
  localparam logic [2:0]  EpochWeekday   = 3'd4;
  localparam logic [3:0]  LastMonth      = 4'd11;

  // Reciprocals for 675, 225 and 15 scaled by 2^25, 2^21 and 2^14. The low
  // power-of-two factor of each divisor is shifted off before the multiply.
  localparam logic [15:0] DayRecip       = 16'd49711;
  localparam logic [13:0] HourRecip      = 14'd9321;
  localparam logic [10:0] MinRecip       = 11'd1093;

  typedef enum logic [1:0] {
    DIV_DAY  = 2'd0,
    DIV_HOUR = 2'd1,
    DIV_MIN  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     year_step;
    logic     month_step;
    logic     div_step;
    div_sel_e div_sel;
    logic     publish;
  } e2cal_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_free;
  } e2cal_sts_t;

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] d;
    case (m)
      4'd1:                      d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] days_mod7(logic [4:0] d);
    logic [4:0] r;
    if (d >= 5'd28) begin
      r = d - 5'd28;
    end else if (d >= 5'd21) begin
      r = d - 5'd21;
    end else if (d >= 5'd14) begin
      r = d - 5'd14;
    end else if (d >= 5'd7) begin
      r = d - 5'd7;
    end else begin
      r = d;
    end
    return r[2:0];
  endfunction

  function automatic logic [2:0] add_mod7(logic [2:0] a, logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

endpackage

>>> rtl/core/e2cal_ctrl.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: controller
// Sequences the year, month and field-split phases and hands the finished
// result to the output register.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_assert.svh"

module e2cal_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  e2cal_pkg::e2cal_sts_t sts_i,
  output e2cal_pkg::e2cal_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_YEAR   = 7'b0000010,
    S_MONTH  = 7'b0000100,
    S_DAY    = 7'b0001000,
    S_HOUR   = 7'b0010000,
    S_MIN    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sts_i.year_done) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts_i.month_done) begin
          state_d = S_DAY;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_DAY: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = e2cal_pkg::DIV_DAY;
        state_d        = S_HOUR;
      end
      S_HOUR: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = e2cal_pkg::DIV_HOUR;
        state_d        = S_MIN;
      end
      S_MIN: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = e2cal_pkg::DIV_MIN;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `E2C_ASSERT_NEXT(a_load_starts_year, cmd_o.load, state_q == S_YEAR)
  `E2C_ASSERT_NEXT(a_publish_idles, cmd_o.publish, state_q == S_IDLE)
  `E2C_ASSERT_NEXT(a_min_ends_div, state_q == S_MIN, state_q == S_FINISH)

endmodule

>>> rtl/core/e2cal_dp.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: datapath
// Holds the remaining seconds, strips years and months by subtraction, splits
// the rest into day, hour and minute one field a cycle by reciprocal
// multiplication, and keeps the weekday as a running sum modulo seven.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_assert.svh"

module e2cal_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  e2cal_pkg::e2cal_cmd_t cmd_i,
  input  logic [31:0]           in_data_i,
  output e2cal_pkg::e2cal_sts_t sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [47:0]           out_data_o
);

  logic [31:0] rest_q, rest_d;
  logic [11:0] year_q, year_d;
  logic [6:0]  y100_q, y100_d;
  logic [8:0]  y400_q, y400_d;
  logic [3:0]  month_q, month_d;
  logic [2:0]  wday_q, wday_d;
  logic [4:0]  day0_q, day0_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic        out_valid_q;
  logic [47:0] out_data_q;

  logic        leap;
  logic [24:0] ylen;
  logic [4:0]  mdays;
  logic [21:0] mlen;
  logic [29:0] day_prod;
  logic [4:0]  day_quo;
  logic [21:0] day_sub;
  logic [25:0] hour_prod;
  logic [4:0]  hour_quo;
  logic [16:0] hour_sub;
  logic [19:0] min_prod;
  logic [5:0]  min_quo;
  logic [11:0] min_sub;
  logic [4:0]  day;

  assign leap  = (y100_q == 7'd0) ? (y400_q == 9'd0) : (year_q[1:0] == 2'd0);
  assign ylen  = leap ? e2cal_pkg::SecsLeapYear : e2cal_pkg::SecsCommonYear;
  assign mdays = e2cal_pkg::month_days(month_q, leap);
  assign mlen  = 22'(mdays) * 22'(e2cal_pkg::SecsPerDay);

  // Day phase: rest is below 31 days. Hour phase: below one day.
  // Minute phase: below one hour.
  assign day_prod  = 30'(rest_q[21:7]) * 30'(e2cal_pkg::DayRecip);
  assign day_quo   = day_prod[29:25];
  assign day_sub   = 22'(day_quo) * 22'(e2cal_pkg::SecsPerDay);
  assign hour_prod = 26'(rest_q[16:4]) * 26'(e2cal_pkg::HourRecip);
  assign hour_quo  = hour_prod[25:21];
  assign hour_sub  = 17'(hour_quo) * 17'(e2cal_pkg::SecsPerHour);
  assign min_prod  = 20'(rest_q[11:2]) * 20'(e2cal_pkg::MinRecip);
  assign min_quo   = min_prod[19:14];
  assign min_sub   = 12'(min_quo) * 12'(e2cal_pkg::SecsPerMin);

  assign sts_o.year_done  = (rest_q < 32'(ylen));
  assign sts_o.month_done = (month_q == e2cal_pkg::LastMonth) || (rest_q < 32'(mlen));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    rest_d   = rest_q;
    year_d   = year_q;
    y100_d   = y100_q;
    y400_d   = y400_q;
    month_d  = month_q;
    wday_d   = wday_q;
    day0_d   = day0_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    if (cmd_i.load) begin
      rest_d   = in_data_i;
      year_d   = e2cal_pkg::EpochYear;
      y100_d   = e2cal_pkg::EpochMod100;
      y400_d   = e2cal_pkg::EpochMod400;
      month_d  = '0;
      wday_d   = e2cal_pkg::EpochWeekday;
      day0_d   = '0;
      hour_d   = '0;
      minute_d = '0;
    end else if (cmd_i.year_step) begin
      rest_d = rest_q - 32'(ylen);
      year_d = year_q + 12'd1;
      y100_d = (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
      y400_d = (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
      wday_d = e2cal_pkg::add_mod7(wday_q, leap ? 3'd2 : 3'd1);
    end else if (cmd_i.month_step) begin
      rest_d  = rest_q - 32'(mlen);
      month_d = month_q + 4'd1;
      wday_d  = e2cal_pkg::add_mod7(wday_q, e2cal_pkg::days_mod7(mdays));
    end else if (cmd_i.div_step) begin
      case (cmd_i.div_sel)
        e2cal_pkg::DIV_DAY: begin
          rest_d = rest_q - 32'(day_sub);
          day0_d = day_quo;
          wday_d = e2cal_pkg::add_mod7(wday_q, e2cal_pkg::days_mod7(day_quo));
        end
        e2cal_pkg::DIV_HOUR: begin
          rest_d = rest_q - 32'(hour_sub);
          hour_d = hour_quo;
        end
        default: begin
          rest_d   = rest_q - 32'(min_sub);
          minute_d = min_quo;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q     <= '0;
      wday_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      month_q <= month_d;
      wday_q  <= wday_d;
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign day = day0_q + 5'd1;

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    year_q   <= year_d;
    y100_q   <= y100_d;
    y400_q   <= y400_d;
    day0_q   <= day0_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    if (cmd_i.publish) begin
      out_data_q <= {7'd0, wday_q, rest_q[5:0], minute_q, hour_q, day,
                     month_q + 4'd1, year_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `E2C_ASSERT_SAME(a_month_in_range, 1'b1, month_q <= e2cal_pkg::LastMonth)
  `E2C_ASSERT_NEXT(a_year_advances, cmd_i.year_step, year_q == $past(year_q) + 12'd1)
  `E2C_ASSERT_NEXT(a_publish_shows, cmd_i.publish, out_valid_q)

endmodule

>>> rtl/core/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: top level
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
// One conversion runs at a time. After a transfer in, the block strips whole
// years by subtraction, then the whole months of the final year, splits off
// day, hour and minute by reciprocal multiplication, and loads the output
// register once it is free. The year subtraction loop dominates the time a
// conversion takes. The output register holds a finished result until it
// is taken, while the next input transfer is already accepted.
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
  // [37:32] second, [40:38] weekday, [47:41] zero
  output logic [47:0] m_axis_tdata
);

  e2cal_pkg::e2cal_cmd_t cmd;
  e2cal_pkg::e2cal_sts_t sts;

  e2cal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  e2cal_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> tb/tb_epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: testbench
// Streams directed and random second counts into the converter with random
// gaps on both sides, predicts each date, time and weekday independently,
// and checks every output transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

  localparam int unsigned RandomItems = 550;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned IdlePercent = 27;
  localparam int unsigned CalmFrom    = 250;
  localparam int unsigned CalmTo      = 350;

  localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  logic [31:0] pending_secs [$];
  calendar_t   expected_dates [$];

  int unsigned in_count;
  int unsigned out_count;
  int unsigned total_items;
  int unsigned failures;
  int unsigned idle_cycles;
  int unsigned min_year;
  int unsigned max_year;
  bit          in_fire;

  epoch_seconds_to_calendar uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic bit is_leap(int unsigned yr);
    if (yr % 100 == 0) begin
      return (yr % 400) == 0;
    end
    return (yr % 4) == 0;
  endfunction

  function automatic calendar_t to_calendar(logic [31:0] secs);
    calendar_t   c;
    int unsigned left;
    int unsigned yr;
    int unsigned mo;
    int unsigned span;
    left = secs;
    yr   = 1970;
    forever begin
      span = is_leap(yr) ? 31622400 : 31536000;
      if (left < span) break;
      left -= span;
      yr++;
    end
    mo = 0;
    while (mo < 11) begin
      span = (MonthLen[mo] + ((mo == 1 && is_leap(yr)) ? 1 : 0)) * 86400;
      if (left < span) break;
      left -= span;
      mo++;
    end
    c.year    = 12'(yr);
    c.month   = 4'(mo + 1);
    c.day     = 5'(left / 86400 + 1);
    left      = left % 86400;
    c.hour    = 5'(left / 3600);
    c.minute  = 6'((left % 3600) / 60);
    c.second  = 6'(left % 60);
    // The epoch day was a Thursday.
    c.weekday = 3'((int'(secs / 86400) + 4) % 7);
    return c;
  endfunction

  function automatic logic [31:0] year_start(int unsigned yr);
    int unsigned acc;
    acc = 0;
    for (int unsigned y = 1970; y < yr; y++) begin
      acc += is_leap(y) ? 31622400 : 31536000;
    end
    return acc;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      in_fire = 1'b0;
      if (pending_secs.size() > 0 &&
          ((in_count >= CalmFrom && in_count < CalmTo) ||
           $urandom_range(99, 0) >= IdlePercent)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_secs.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= (out_count >= CalmFrom && out_count < CalmTo) ||
                       ($urandom_range(99, 0) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin : monitor
    calendar_t want;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(to_calendar(s_axis_tdata));
        in_count++;
        in_fire = 1'b1;
        moved   = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        out_count++;
        if (expected_dates.size() == 0) begin
          $error("output transfer with no conversion pending: %h", m_axis_tdata);
          failures++;
        end else begin
          want = expected_dates.pop_front();
          if (m_axis_tdata[11:0] != want.year) begin
            $error("year: expected %0d, got %0d", want.year, m_axis_tdata[11:0]);
            failures++;
          end
          if (m_axis_tdata[15:12] != want.month) begin
            $error("month: expected %0d, got %0d", want.month, m_axis_tdata[15:12]);
            failures++;
          end
          if (m_axis_tdata[20:16] != want.day) begin
            $error("day: expected %0d, got %0d", want.day, m_axis_tdata[20:16]);
            failures++;
          end
          if (m_axis_tdata[25:21] != want.hour) begin
            $error("hour: expected %0d, got %0d", want.hour, m_axis_tdata[25:21]);
            failures++;
          end
          if (m_axis_tdata[31:26] != want.minute) begin
            $error("minute: expected %0d, got %0d", want.minute, m_axis_tdata[31:26]);
            failures++;
          end
          if (m_axis_tdata[37:32] != want.second) begin
            $error("second: expected %0d, got %0d", want.second, m_axis_tdata[37:32]);
            failures++;
          end
          if (m_axis_tdata[40:38] != want.weekday) begin
            $error("weekday: expected %0d, got %0d", want.weekday, m_axis_tdata[40:38]);
            failures++;
          end
          if (want.year < min_year) min_year = want.year;
          if (want.year > max_year) max_year = want.year;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] secs;
    int unsigned kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    in_fire       = 1'b0;
    in_count      = 0;
    out_count     = 0;
    total_items   = 0;
    failures      = 0;
    idle_cycles   = 0;
    min_year      = 4095;
    max_year      = 0;

    // Range ends, year and leap-day edges, the skipped century leap day.
    pending_secs = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                     32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
                     32'd68169600, 32'd946684799, 32'd951782400, 32'd978307199,
                     32'd4107542399, 32'd4107542400, 32'd2147483647,
                     32'd2147483648, 32'd4291747199, 32'd4291747200,
                     32'h5555_5555, 32'hAAAA_AAAA};

    for (int unsigned i = 0; i < RandomItems; i++) begin
      kind = $urandom_range(9, 0);
      if (kind < 4) begin
        secs = $urandom;
      end else if (kind < 8) begin
        secs = $urandom_range(49710, 0) * 86400;
        case ($urandom_range(2, 0))
          0:       secs = (secs == 0) ? secs : secs - 1;
          1:       secs = secs + $urandom_range(86399, 0);
          default: ;
        endcase
      end else begin
        secs = year_start($urandom_range(2106, 1971));
        secs = secs - 1 + $urandom_range(2, 0);
      end
      pending_secs.push_back(secs);
    end
    total_items = pending_secs.size();

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (out_count < total_items) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    $display("Checked %0d conversions spanning years %0d to %0d.", out_count, min_year,
             max_year);
    if (failures == 0 && in_count == total_items && out_count == total_items &&
        expected_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/e2cal_pkg.sv
rtl/core/e2cal_ctrl.sv
rtl/core/e2cal_dp.sv
rtl/core/epoch_seconds_to_calendar.sv
tb/tb_epoch_seconds_to_calendar.sv
